>>> sv/svdl_pkg.sv
// Shared constants, types and saturation helpers of the vibrato delay line.
`timescale 1ns / 1ps
`default_nettype none

package svdl_pkg;

  // Sizes. RING_DEPTH and TABLE_DEPTH are powers of two.
  localparam int RING_DEPTH  = 1024;
  localparam int TABLE_DEPTH = 2048;
  localparam int SAMPLE_W    = 24;
  localparam int NUM_BANKS   = 3;

  localparam int FRAC_W      = 16;
  localparam int RING_W      = SAMPLE_W + 2;
  localparam int WIDE_W      = RING_W + 2;
  localparam int RA_W        = $clog2(RING_DEPTH);
  localparam int POS_W       = RA_W + FRAC_W;
  localparam int TI_W        = $clog2(TABLE_DEPTH);
  localparam int PH_W        = TI_W + FRAC_W;
  localparam int TBL_ENTRIES = NUM_BANKS * TABLE_DEPTH;
  localparam int TBL_AW      = $clog2(TBL_ENTRIES);
  localparam int G_W         = SAMPLE_W + 1;

  // Fixed input field widths.
  localparam int BANK_W      = 2;
  localparam int INDEX_W     = 11;
  localparam int WORD_W      = 26;
  localparam int INC_W       = 20;

  localparam logic [RA_W-1:0] RP_RESET = RA_W'((RING_DEPTH - 1) / 2);

  // 1/sqrt(2) in Q24, rounded.
  localparam int MIX_W     = 25;
  localparam int MIX_SHIFT = 24;
  localparam int MPROD_W   = RING_W + 1 + MIX_W;
  localparam logic signed [MIX_W-1:0] MIX_Q24 = 25'sd11863283;
  localparam int MIX_HALF  = 1 << (MIX_SHIFT - 1);

  // Configuration port.
  localparam int CFG_AW = 2;
  localparam int CFG_DW = INC_W;
  localparam logic [CFG_AW-1:0] REG_PHASE_INC = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DEPTH_SEL = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MIX_EN    = 2'd2;
  localparam logic [BANK_W-1:0] DEPTH_RESET   = 2'd2;

  // Input opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TABLE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC_H,
    ST_ACC_K,
    ST_OUT
  } eng_state_e;

  // One audio item handed from the front end to the ring engine.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic [RA_W-1:0]            rp;
    logic [WORD_W-1:0]          word;
  } item_t;

  // Engine status seen by the front end.
  typedef struct packed {
    logic take;
    logic clr_busy;
  } eng_stat_t;

  function automatic logic signed [RING_W-1:0] sat_ring(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-RING_W:0] top;
    logic signed [RING_W-1:0] r;
    top = v[WIDE_W-1:RING_W-1];
    if ((&top) || !(|top)) begin
      r = v[RING_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(RING_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(RING_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-SAMPLE_W:0] top;
    logic signed [SAMPLE_W-1:0] r;
    top = v[WIDE_W-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/scanner_vibrato_delay_line.sv
// Top level of the scanner vibrato delay line: configuration registers and stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Variable-delay vibrato and chorus line.
// Input beats arrive on the s_axis channel. tuser carries the opcode: an audio beat scatters
// its sample linearly into two neighboring slots of a 1024-slot delay ring, at the read
// position plus an offset looked up from one of three offset tables by the LFO phase, and
// returns one sample on m_axis: the ring slot at the read position, plain or mixed with the
// dry sample and scaled by 1/sqrt(2), after which that slot is cleared. A table beat loads
// one offset table word, unless its bank is past the last one, and returns nothing.
// Configuration (phase increment, depth select, mix enable) goes through the write port;
// the user must change it only while no beat is in flight, which the block does not enforce.
// Path: an audio sample passes the front stage, then the engine steps MUL, ACC_H, ACC_K and OUT.
// The ring memory has one read and one write port, and each audio beat needs three reads
// (both scatter slots and the read slot), two scatter writes and the clearing write, walked
// by a four-step sequencer that takes the next beat in its last step. One beat waits in the
// front stage with its table lookup done while the previous one is in the ring, so the input
// side keeps taking beats.
// Reset: a clearing pass writes zero to every ring slot with s_axis_tready
// low; the offset tables are not cleared and must be loaded before they are read.
// When the receiver stalls, the finished sample holds in the output register; the engine
// finishes the next beat and waits, and the input side then stops once its stage is full.
module scanner_vibrato_delay_line (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Input stream.
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: sample_in[23:0], table_bank[25:24], table_index[36:26],
  // table_word[62:37], zero pad [63].
  input  wire  [63:0]                         s_axis_tdata,
  // tuser: op[0].
  input  wire  [0:0]                          s_axis_tuser,
  // Output stream.
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // tdata: sample_out[23:0].
  output logic [23:0]                         m_axis_tdata,
  // Configuration write port.
  input  wire                                 cfg_we_i,
  input  wire  [svdl_pkg::CFG_AW-1:0]         cfg_index_i,
  input  wire  [svdl_pkg::CFG_DW-1:0]         cfg_data_i
);

  logic [svdl_pkg::INC_W-1:0]  inc_q, inc_d;
  logic [svdl_pkg::BANK_W-1:0] depth_q, depth_d;
  logic                        mix_q, mix_d;

  logic                        item_valid;
  svdl_pkg::item_t             item;
  svdl_pkg::eng_stat_t         eng_stat;
  logic signed [svdl_pkg::SAMPLE_W-1:0] out_data;

  // Register writes; an index past the list is dropped.
  always_comb begin
    inc_d   = inc_q;
    depth_d = depth_q;
    mix_d   = mix_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        svdl_pkg::REG_PHASE_INC: inc_d   = cfg_data_i[svdl_pkg::INC_W-1:0];
        svdl_pkg::REG_DEPTH_SEL: depth_d = cfg_data_i[svdl_pkg::BANK_W-1:0];
        svdl_pkg::REG_MIX_EN:    mix_d   = cfg_data_i[0];
        default:                 inc_d   = inc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q   <= '0;
      depth_q <= svdl_pkg::DEPTH_RESET;
      mix_q   <= 1'b0;
    end else begin
      inc_q   <= inc_d;
      depth_q <= depth_d;
      mix_q   <= mix_d;
    end
  end

  svdl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser[0]),
    .in_sample_i  ($signed(s_axis_tdata[23:0])),
    .in_bank_i    (s_axis_tdata[25:24]),
    .in_index_i   (s_axis_tdata[36:26]),
    .in_word_i    (s_axis_tdata[62:37]),
    .phase_inc_i  (inc_q),
    .depth_sel_i  (depth_q),
    .eng_stat_i   (eng_stat),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  svdl_ring_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .mix_en_i     (mix_q),
    .stat_o       (eng_stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_data)
  );

  assign m_axis_tdata = out_data;

endmodule

`default_nettype wire

>>> sv/svdl_front.sv
// Front end: offset table memory, LFO phase, read position and the item holding stage.
`timescale 1ns / 1ps
`default_nettype none

module svdl_front (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire                                   in_op_i,
  input  wire  signed [svdl_pkg::SAMPLE_W-1:0]  in_sample_i,
  input  wire         [svdl_pkg::BANK_W-1:0]    in_bank_i,
  input  wire         [svdl_pkg::INDEX_W-1:0]   in_index_i,
  input  wire         [svdl_pkg::WORD_W-1:0]    in_word_i,
  input  wire         [svdl_pkg::INC_W-1:0]     phase_inc_i,
  input  wire         [svdl_pkg::BANK_W-1:0]    depth_sel_i,
  input  svdl_pkg::eng_stat_t                   eng_stat_i,
  output logic                                  item_valid_o,
  output svdl_pkg::item_t                       item_o
);

  logic [svdl_pkg::WORD_W-1:0] tbl_mem [svdl_pkg::TBL_ENTRIES];
  logic [svdl_pkg::WORD_W-1:0] tbl_rdata_q;

  logic                               f_valid_q, f_valid_d;
  logic signed [svdl_pkg::SAMPLE_W-1:0] f_x_q;
  logic [svdl_pkg::RA_W-1:0]          f_rp_q;
  logic [svdl_pkg::PH_W-1:0]          phase_q, phase_d;
  logic [svdl_pkg::RA_W-1:0]          rp_q, rp_d;

  logic                               acc, acc_smp, acc_tbl;
  logic [svdl_pkg::BANK_W-1:0]        rbank;
  logic [svdl_pkg::TBL_AW-1:0]        raddr, waddr;

  assign in_ready_o = !eng_stat_i.clr_busy && (!f_valid_q || eng_stat_i.take);
  assign acc        = in_valid_i && in_ready_o;
  assign acc_smp    = acc && (in_op_i == svdl_pkg::OP_SAMPLE);
  assign acc_tbl    = acc && (in_op_i == svdl_pkg::OP_TABLE)
                      && (int'(in_bank_i) < svdl_pkg::NUM_BANKS)
                      && (int'(in_index_i) < svdl_pkg::TABLE_DEPTH);

  // Depth select three falls back to the last bank.
  assign rbank = (int'(depth_sel_i) >= svdl_pkg::NUM_BANKS)
                 ? svdl_pkg::BANK_W'(svdl_pkg::NUM_BANKS - 1) : depth_sel_i;

  assign raddr = svdl_pkg::TBL_AW'(rbank) * svdl_pkg::TBL_AW'(svdl_pkg::TABLE_DEPTH)
                 + svdl_pkg::TBL_AW'(phase_q[svdl_pkg::PH_W-1:svdl_pkg::FRAC_W]);
  assign waddr = svdl_pkg::TBL_AW'(in_bank_i) * svdl_pkg::TBL_AW'(svdl_pkg::TABLE_DEPTH)
                 + svdl_pkg::TBL_AW'(in_index_i);

  // The read data register only moves on a sample beat, so it stays with the held item.
  always_ff @(posedge clk_i) begin
    if (acc_tbl) begin
      tbl_mem[waddr] <= in_word_i;
    end
    if (acc_smp) begin
      tbl_rdata_q <= tbl_mem[raddr];
    end
  end

  always_comb begin
    f_valid_d = f_valid_q;
    phase_d   = phase_q;
    rp_d      = rp_q;
    if (eng_stat_i.take) begin
      f_valid_d = 1'b0;
    end
    if (acc_smp) begin
      f_valid_d = 1'b1;
      phase_d   = phase_q + svdl_pkg::PH_W'(phase_inc_i);
      rp_d      = rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      phase_q   <= '0;
      rp_q      <= svdl_pkg::RP_RESET;
    end else begin
      f_valid_q <= f_valid_d;
      phase_q   <= phase_d;
      rp_q      <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_smp) begin
      f_x_q  <= in_sample_i;
      f_rp_q <= rp_q;
    end
  end

  assign item_valid_o = f_valid_q;
  assign item_o       = '{x: f_x_q, rp: f_rp_q, word: tbl_rdata_q};

endmodule

`default_nettype wire

>>> sv/svdl_ring_engine.sv
// Ring engine: delay ring memory, clearing pass, scatter/read sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none

module svdl_ring_engine (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   item_valid_i,
  input  svdl_pkg::item_t                       item_i,
  input  wire                                   mix_en_i,
  output svdl_pkg::eng_stat_t                   stat_o,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [svdl_pkg::SAMPLE_W-1:0]  out_data_o
);

  logic [svdl_pkg::RING_W-1:0] ring_mem [svdl_pkg::RING_DEPTH];
  logic [svdl_pkg::RING_W-1:0] rd_q;

  svdl_pkg::eng_state_e state_q, state_d;

  logic                                 clr_busy_q, clr_busy_d;
  logic [svdl_pkg::RA_W-1:0]            clr_addr_q, clr_addr_d;
  logic                                 out_valid_q, out_valid_d;
  logic signed [svdl_pkg::SAMPLE_W-1:0] out_data_q;

  logic signed [svdl_pkg::SAMPLE_W-1:0] x_q;
  logic [svdl_pkg::RA_W-1:0]            rp_q, h_q, k_q;
  logic [svdl_pkg::FRAC_W-1:0]          f_q;
  logic signed [svdl_pkg::G_W-1:0]      g_q;
  logic                                 fwd_q;
  logic signed [svdl_pkg::RING_W-1:0]   fwd_val_q;

  logic                                 take, out_free;
  logic [svdl_pkg::POS_W-1:0]           pos;
  logic signed [svdl_pkg::SAMPLE_W+svdl_pkg::FRAC_W:0] gprod;
  logic signed [svdl_pkg::RING_W-1:0]   rd_s, sum_h, sum_k, ring_v;
  logic signed [svdl_pkg::RING_W:0]     mix_sum;
  logic signed [svdl_pkg::MPROD_W-1:0]  mprod, mrnd;
  logic signed [svdl_pkg::SAMPLE_W-1:0] y;

  logic                                 re, we;
  logic [svdl_pkg::RA_W-1:0]            ra, wa;
  logic [svdl_pkg::RING_W-1:0]          wd;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = item_valid_i && !clr_busy_q
                    && ((state_q == svdl_pkg::ST_IDLE)
                        || ((state_q == svdl_pkg::ST_OUT) && out_free));
  assign stat_o   = '{take: take, clr_busy: clr_busy_q};

  // Write position from the read position and the table offset.
  assign pos = svdl_pkg::POS_W'({item_i.rp, {svdl_pkg::FRAC_W{1'b0}}})
               + svdl_pkg::POS_W'(item_i.word);

  assign gprod = x_q * $signed({1'b0, f_q});
  assign rd_s  = $signed(rd_q);
  assign sum_h = svdl_pkg::sat_ring(svdl_pkg::WIDE_W'(rd_s) + svdl_pkg::WIDE_W'(x_q)
                                    - svdl_pkg::WIDE_W'(g_q));
  assign sum_k = svdl_pkg::sat_ring(svdl_pkg::WIDE_W'(rd_s) + svdl_pkg::WIDE_W'(g_q));

  // When the read slot equals the neighbor entry written in the same cycle, take the new value.
  assign ring_v  = fwd_q ? fwd_val_q : rd_s;
  assign mix_sum = (svdl_pkg::RING_W+1)'(x_q) + (svdl_pkg::RING_W+1)'(ring_v);
  assign mprod   = mix_sum * svdl_pkg::MIX_Q24;
  assign mrnd    = mprod + svdl_pkg::MPROD_W'(svdl_pkg::MIX_HALF);
  assign y       = mix_en_i
                   ? svdl_pkg::sat_out(mrnd[svdl_pkg::MPROD_W-1:svdl_pkg::MIX_SHIFT])
                   : svdl_pkg::sat_out(svdl_pkg::WIDE_W'(ring_v));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      svdl_pkg::ST_IDLE:  if (take) state_d = svdl_pkg::ST_MUL;
      svdl_pkg::ST_MUL:   state_d = svdl_pkg::ST_ACC_H;
      svdl_pkg::ST_ACC_H: state_d = svdl_pkg::ST_ACC_K;
      svdl_pkg::ST_ACC_K: state_d = svdl_pkg::ST_OUT;
      svdl_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = take ? svdl_pkg::ST_MUL : svdl_pkg::ST_IDLE;
        end
      end
      default:            state_d = svdl_pkg::ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    re = 1'b0;
    ra = h_q;
    we = 1'b0;
    wa = h_q;
    wd = '0;
    case (state_q)
      svdl_pkg::ST_MUL: begin
        re = 1'b1;
        ra = h_q;
      end
      svdl_pkg::ST_ACC_H: begin
        we = 1'b1;
        wa = h_q;
        wd = sum_h;
        re = 1'b1;
        ra = k_q;
      end
      svdl_pkg::ST_ACC_K: begin
        we = 1'b1;
        wa = k_q;
        wd = sum_k;
        re = 1'b1;
        ra = rp_q;
      end
      svdl_pkg::ST_OUT: begin
        we = out_free;
        wa = rp_q;
        wd = '0;
      end
      default: begin
        re = 1'b0;
      end
    endcase
    if (clr_busy_q) begin
      we = 1'b1;
      wa = clr_addr_q;
      wd = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      ring_mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= ring_mem[ra];
    end
  end

  always_comb begin
    clr_busy_d  = clr_busy_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == svdl_pkg::RA_W'(svdl_pkg::RING_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == svdl_pkg::ST_OUT) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svdl_pkg::ST_IDLE;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q  <= item_i.x;
      rp_q <= item_i.rp;
      h_q  <= pos[svdl_pkg::POS_W-1:svdl_pkg::FRAC_W];
      k_q  <= pos[svdl_pkg::POS_W-1:svdl_pkg::FRAC_W] + 1'b1;
      f_q  <= pos[svdl_pkg::FRAC_W-1:0];
    end
    if (state_q == svdl_pkg::ST_MUL) begin
      g_q <= gprod[svdl_pkg::SAMPLE_W+svdl_pkg::FRAC_W:svdl_pkg::FRAC_W];
    end
    if (state_q == svdl_pkg::ST_ACC_K) begin
      fwd_q     <= (rp_q == k_q);
      fwd_val_q <= sum_k;
    end
    if ((state_q == svdl_pkg::ST_OUT) && out_free) begin
      out_data_q <= y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (state_q == svdl_pkg::ST_IDLE))
    else $error("ring engine left idle during the clearing pass");

  a_neighbor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svdl_pkg::ST_ACC_H) |-> (k_q == svdl_pkg::RA_W'(h_q + 1'b1)))
    else $error("neighbor entry is not the next ring slot");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svdl_pkg::ST_ACC_K) |=> (state_q == svdl_pkg::ST_OUT))
    else $error("read slot step did not follow the neighbor update");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == svdl_pkg::ST_OUT) && !out_free) |=>
      ((state_q == svdl_pkg::ST_OUT) && $stable(rp_q)))
    else $error("engine moved on while the output register was full");

  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == svdl_pkg::ST_OUT) && out_free) |=> out_valid_q)
    else $error("finished item did not reach the output register");

endmodule

`default_nettype wire
